// ----- sv/dps_pkg.sv -----
// Shared types and constants for the dynamic priority scheduler.
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int SLOT_W        = 3;
   localparam int SLOT_WIDE_W   = 7;
   localparam int TIME_W        = 8;
   localparam int PRIO_W        = 8;
   localparam int COUNT_W       = 32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] load_time;
      logic [PRIO_W-1:0] load_priority;
   } req_type;

   typedef struct packed {
      logic               ran;
      logic [SLOT_W-1:0]  chosen_slot;
      logic [TIME_W-1:0]  time_left;
      logic [PRIO_W-1:0]  priority_now;
      logic               finished;
      logic               idle;
      logic [COUNT_W-1:0] tick_count;
   } rsp_type;

   // table write port (address travels separately, its width follows SLOTS)
   typedef struct packed {
      logic              en;
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] prio;
      logic              ready;
   } tbl_wr_type;

   // registered table read data
   typedef struct packed {
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] prio;
      logic              ready;
   } tbl_rd_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ----- sv/dynamic_priority_scheduler_top.sv -----
// Top level of the dynamic priority scheduler.
//
//   channel   ports                     transfer
//   request   start, busy, req_data     start high while busy low
//   response  rsp_valid, rsp_data       one-cycle strobe, always taken
//
// A load goes via FINISH to its response, a tick via SCAN, DRAIN, UPDATE and
// FINISH; the scan reads one slot per cycle from the table memory through
// the one priority comparator. busy is high until the response strobe.
// Synchronous reset clears the ready flags, the tick count and the sequencer;
// slot contents are left as they are. The response side has no stall.
`timescale 1ns / 1ps
`default_nettype none

module dynamic_priority_scheduler_top #(
   parameter int SLOTS = dps_pkg::SLOTS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire dps_pkg::req_type req_data,
   output logic                  rsp_valid,
   output dps_pkg::rsp_type      rsp_data
);
   import dps_pkg::*;

   logic [$clog2(SLOTS)-1:0] wr_addr;
   logic [$clog2(SLOTS)-1:0] rd_addr;
   tbl_wr_type               wr;
   tbl_rd_type               rd;
   logic                     any_ready;

   dps_ctrl #(
      .SLOTS(SLOTS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .wr_addr  (wr_addr),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd       (rd),
      .any_ready(any_ready)
   );

   dps_table #(
      .SLOTS(SLOTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_addr  (wr_addr),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd       (rd),
      .any_ready(any_ready)
   );

endmodule

`default_nettype wire

// ----- sv/dps_table.sv -----
// Task slot table: run time and priority memories plus ready flags.
`timescale 1ns / 1ps
`default_nettype none

module dps_table #(
   parameter int SLOTS = dps_pkg::SLOTS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
   input  wire dps_pkg::tbl_wr_type      wr,
   input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
   output dps_pkg::tbl_rd_type           rd,
   output logic                          any_ready
);
   import dps_pkg::*;

   logic [TIME_W-1:0] rem_mem  [SLOTS];
   logic [PRIO_W-1:0] prio_mem [SLOTS];
   logic [SLOTS-1:0]  ready_ff;
   tbl_rd_type        rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rem_mem[wr_addr]  <= wr.remaining;
         prio_mem[wr_addr] <= wr.prio;
      end
      rd_ff.remaining <= rem_mem[rd_addr];
      rd_ff.prio      <= prio_mem[rd_addr];
      rd_ff.ready     <= ready_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= '0;
      end else if (wr.en) begin
         ready_ff[wr_addr] <= wr.ready;
      end
   end

   assign rd        = rd_ff;
   assign any_ready = |ready_ff;

endmodule

`default_nettype wire

// ----- sv/dps_ctrl.sv -----
// Sequencer: slot load, slot scan with a shared priority compare, slot update and response.
`timescale 1ns / 1ps
`default_nettype none

module dps_ctrl #(
   parameter int SLOTS = dps_pkg::SLOTS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire dps_pkg::req_type         req_data,
   output logic                          rsp_valid,
   output dps_pkg::rsp_type              rsp_data,
   output logic [$clog2(SLOTS)-1:0]      wr_addr,
   output dps_pkg::tbl_wr_type           wr,
   output logic [$clog2(SLOTS)-1:0]      rd_addr,
   input  wire dps_pkg::tbl_rd_type      rd,
   input  wire logic                     any_ready
);
   import dps_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   state_type          state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]  best_rem_ff, best_rem_in;
   logic [PRIO_W-1:0]  best_prio_ff, best_prio_in;
   logic [COUNT_W-1:0] elapsed_ff, elapsed_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [SLOT_WIDE_W-1:0] slot_wide;
   logic                   slot_ok;
   logic                   better;
   logic [TIME_W-1:0]      rem_dec;
   logic [PRIO_W-1:0]      prio_dec;

   assign slot_wide = SLOT_WIDE_W'(req_data.slot);
   assign slot_ok   = slot_wide < SLOT_WIDE_W'(SLOTS);
   assign better    = cmp_vld_ff && rd.ready && (!found_ff || (rd.prio > best_prio_ff));
   assign rem_dec   = (best_rem_ff != '0) ? best_rem_ff - TIME_W'(1) : best_rem_ff;
   assign prio_dec  = (best_prio_ff != '0) ? best_prio_ff - PRIO_W'(1) : best_prio_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_rem_in  = best_rem_ff;
      best_prio_in = best_prio_ff;
      elapsed_in   = elapsed_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_addr      = best_idx_ff;
      wr           = '0;
      rd_addr      = idx_ff;

      if (better) begin
         found_in     = 1'b1;
         best_idx_in  = cmp_idx_ff;
         best_rem_in  = rd.remaining;
         best_prio_in = rd.prio;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               res_in = '0;
               if (req_data.operation == OP_LOAD) begin
                  wr_addr      = slot_wide[IW-1:0];
                  wr.en        = slot_ok;
                  wr.remaining = req_data.load_time;
                  wr.prio      = req_data.load_priority;
                  wr.ready     = 1'b1;
                  state_in     = ST_FINISH;
               end else begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (found_ff) begin
               wr.en              = 1'b1;
               wr.remaining       = rem_dec;
               wr.prio            = prio_dec;
               wr.ready           = rem_dec != '0;
               elapsed_in         = elapsed_ff + COUNT_W'(1);
               res_in.ran         = 1'b1;
               res_in.chosen_slot = SLOT_W'(best_idx_ff);
               res_in.time_left   = rem_dec;
               res_in.priority_now = prio_dec;
               res_in.finished    = rem_dec == '0;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_in            = res_ff;
            rsp_in.idle       = !any_ready;
            rsp_in.tick_count = elapsed_ff;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_rem_ff  <= best_rem_in;
      best_prio_ff <= best_prio_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
